// ===== design/tsf_pkg.sv =====
// tsf_pkg: shared types and constants for the trapezoid span fill block
// no dependencies; imported by trapezoid_span_fill
`default_nettype none

package tsf_pkg;

	// screen geometry
	localparam int CFG_W    = 13;   // width of the screen size registers
	localparam int SPAN_W   = 12;   // width of the span x outputs
	localparam int SPAN_MAX = 4096; // widest span the outputs can express

	// item kinds on the input channel
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_ROW  = 1'b1;

	// register index, taken from paddr[2]
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// edge stepping sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LADD,
		ST_LSUB,
		ST_RADD,
		ST_RSUB
	} tsf_state_t;

endpackage

`default_nettype wire

// ===== design/trapezoid_span_fill.sv =====
// trapezoid_span_fill: top level, scan converts a trapezoid into row spans
// depends on tsf_pkg for the widths, opcodes, sequencer states and register codes
`default_nettype none

// usage
//  input channel s_*: s_tuser is the kind, load a new trapezoid or emit the
//   next row; s_tdata carries the six row and edge coordinates
//  output channel m_*: one item per input item, m_tuser flags a drawable
//   span, m_tlast marks the trapezoid's last row
//  apb port: screen_width at 0x0, screen_height at 0x4, write only while idle
// timing
//  the result is registered and shows in the cycle after the input is taken
//  a load, a row item while idle and the final row need no edge stepping
//  other row items also step both edges on one shared error adder, left
//   then right; an edge already on its goal is skipped, else its error
//   takes the delta once and then the row span off once per unit x move;
//   shallow edges take longer, as they move further in x
// reset
//  no trapezoid is active, width 640, height 480, the output holds nothing
// stalls
//  a result waiting on m_tready holds the output register; the next item is
//  taken only once the register frees and edge stepping has ended

module trapezoid_span_fill
	import tsf_pkg::*;
#(
	parameter int COORD_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	// input items
	input  wire                         s_tvalid,
	output logic                        s_tready,
	// row_bottom, row_top, left_at_bottom, left_at_top, right_at_bottom,
	// right_at_top, zero pad
	input  wire  [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	input  wire                         s_tuser,  // opcode
	// result items
	output logic                        m_tvalid,
	input  wire                         m_tready,
	// row, span_first, span_last, busy_res, zero pad
	output logic [((COORD_WIDTH+25+7)/8)*8-1:0] m_tdata,
	output logic                        m_tuser,  // span_valid
	output logic                        m_tlast,  // final_row
	// configuration
	input  wire                         psel,
	input  wire                         penable,
	input  wire                         pwrite,
	input  wire  [2:0]                  paddr,
	input  wire  [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CW    = COORD_WIDTH;
	localparam int DW    = CW + 1;                    // deltas and row span
	localparam int EW    = CW + 3;                    // error terms
	localparam int KW    = ((CW > CFG_W) ? CW : CFG_W) + 2; // clamp compares
	localparam int OUT_W = ((CW+25+7)/8)*8;
	localparam int OPAD  = OUT_W - (CW + 2*SPAN_W + 1);

	// configuration registers
	logic [CFG_W-1:0] width_q, height_q;
	logic             cfg_wr;

	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(640);
			height_q <= CFG_W'(480);
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WIDTH:  prdata = {{(32-CFG_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-CFG_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	// trapezoid state
	tsf_state_t             state_q, state_d;
	logic                   active_q;
	logic signed [CW-1:0]   cur_row_q, last_row_q;
	logic signed [CW-1:0]   lx_q, lgoal_q, rx_q, rgoal_q;
	logic signed [EW-1:0]   lerr_q, rerr_q;
	logic        [DW-1:0]   ldelta_q, rdelta_q, rspan_q;
	logic                   ldir_q, rdir_q;

	// output register
	logic                   out_vld_q;
	logic [OUT_W-1:0]       out_data_q;
	logic                   out_user_q, out_last_q;

	logic s_acc;
	assign s_tready = (state_q == ST_IDLE) && (!out_vld_q || m_tready);
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

	// load item decode
	logic signed [CW-1:0] yl, yu, xll, xul, xlr, xur;
	assign yl  = s_tdata[0*CW +: CW];
	assign yu  = s_tdata[1*CW +: CW];
	assign xll = s_tdata[2*CW +: CW];
	assign xul = s_tdata[3*CW +: CW];
	assign xlr = s_tdata[4*CW +: CW];
	assign xur = s_tdata[5*CW +: CW];

	logic signed [KW-1:0] height_k, width_k;
	logic signed [KW-1:0] yl_k;
	logic                 ld_ok;
	logic                 ld_ldir, ld_rdir;
	logic signed [DW-1:0] ldiff, rdiff;
	logic        [DW-1:0] ld_ldelta, ld_rdelta, ld_span;
	logic        [DW:0]   lhalf, rhalf;
	logic signed [EW-1:0] ld_lerr, ld_rerr;

	assign height_k = KW'(signed'({1'b0, height_q}));
	// wider screens clamp spans as if they were the widest span
	assign width_k  = (width_q > CFG_W'(SPAN_MAX)) ? KW'(SPAN_MAX)
	                                               : KW'(signed'({1'b0, width_q}));
	assign yl_k     = KW'(yl);

	// rejected when wholly below, wholly above or upside down
	assign ld_ok = !(yl_k >= height_k) && !yu[CW-1] && !(yu < yl);

	assign ld_ldir   = xll < xul;
	assign ld_rdir   = xur > xlr;
	assign ldiff     = DW'(xul) - DW'(xll);
	assign rdiff     = DW'(xur) - DW'(xlr);
	assign ld_ldelta = ld_ldir ? DW'(ldiff) : DW'(-ldiff);
	assign ld_rdelta = ld_rdir ? DW'(rdiff) : DW'(-rdiff);
	assign ld_span   = DW'(DW'(yu) - DW'(yl));
	// initial error is floor of -delta/2
	assign lhalf     = ({1'b0, ld_ldelta} + (DW+1)'(1)) >> 1;
	assign rhalf     = ({1'b0, ld_rdelta} + (DW+1)'(1)) >> 1;
	assign ld_lerr   = -signed'(EW'(lhalf));
	assign ld_rerr   = -signed'(EW'(rhalf));

	// span of the current row, clamped to the screen
	logic signed [KW-1:0] y_k, xs_k, xe_k, xec_k, xl_k;
	logic                 on_screen, row_vld, row_final;
	assign y_k       = KW'(cur_row_q);
	assign on_screen = !cur_row_q[CW-1] && (y_k < height_k);
	assign xs_k      = lx_q[CW-1] ? '0 : KW'(lx_q);
	assign xe_k      = KW'(rx_q) + KW'(1);
	assign xec_k     = (xe_k > width_k) ? width_k : xe_k;
	assign xl_k      = xec_k - KW'(1);
	assign row_vld   = on_screen && (xs_k < xec_k);
	assign row_final = cur_row_q == last_row_q;

	// shared error unit: adds the delta once, then takes off the row span
	// once per unit x move
	logic                 sel_right, add_phase;
	logic signed [EW-1:0] alu_a, alu_b, alu_sum;
	logic signed [CW-1:0] edge_x, edge_goal, edge_x_next;
	logic                 edge_dir, at_goal, err_pos;

	assign sel_right   = (state_q == ST_RADD) || (state_q == ST_RSUB);
	assign add_phase   = (state_q == ST_LADD) || (state_q == ST_RADD);
	assign alu_a       = sel_right ? rerr_q : lerr_q;
	assign alu_b       = add_phase ? EW'(sel_right ? rdelta_q : ldelta_q)
	                               : -EW'(rspan_q);
	assign alu_sum     = alu_a + alu_b;
	assign edge_x      = sel_right ? rx_q : lx_q;
	assign edge_goal   = sel_right ? rgoal_q : lgoal_q;
	assign edge_dir    = sel_right ? rdir_q : ldir_q;
	assign edge_x_next = edge_dir ? edge_x + CW'(1) : edge_x - CW'(1);
	assign at_goal     = edge_x == edge_goal;
	assign err_pos     = !alu_a[EW-1] && (alu_a != '0);

	// sequencer
	logic step_err, step_x;

	always_comb begin
		state_d  = state_q;
		step_err = 1'b0;
		step_x   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// the final row needs no stepping: a load resets every edge
				if (s_acc && (s_tuser == OP_ROW) && active_q && !row_final)
					state_d = ST_LADD;
			end
			ST_LADD, ST_RADD: begin
				if (at_goal) begin
					state_d = (state_q == ST_LADD) ? ST_RADD : ST_IDLE;
				end else begin
					step_err = 1'b1;
					state_d  = (state_q == ST_LADD) ? ST_LSUB : ST_RSUB;
				end
			end
			ST_LSUB, ST_RSUB: begin
				if (err_pos && !at_goal) begin
					step_err = 1'b1;
					step_x   = 1'b1;
				end else begin
					state_d = (state_q == ST_LSUB) ? ST_RADD : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// trapezoid state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			cur_row_q  <= '0;
			last_row_q <= '0;
			lx_q       <= '0;
			lgoal_q    <= '0;
			rx_q       <= '0;
			rgoal_q    <= '0;
			lerr_q     <= '0;
			rerr_q     <= '0;
			ldelta_q   <= '0;
			rdelta_q   <= '0;
			rspan_q    <= '0;
			ldir_q     <= 1'b0;
			rdir_q     <= 1'b0;
		end else if (s_acc) begin
			if (s_tuser == OP_LOAD) begin
				active_q <= ld_ok;
				if (ld_ok) begin
					cur_row_q  <= yl;
					last_row_q <= yu;
					lx_q       <= xll;
					lgoal_q    <= xul;
					rx_q       <= xlr;
					rgoal_q    <= xur;
					lerr_q     <= ld_lerr;
					rerr_q     <= ld_rerr;
					ldelta_q   <= ld_ldelta;
					rdelta_q   <= ld_rdelta;
					rspan_q    <= ld_span;
					ldir_q     <= ld_ldir;
					rdir_q     <= ld_rdir;
				end
			end else if (active_q) begin
				if (row_final)
					active_q <= 1'b0;
				else
					cur_row_q <= cur_row_q + CW'(1);
			end
		end else begin
			if (step_err) begin
				if (sel_right)
					rerr_q <= alu_sum;
				else
					lerr_q <= alu_sum;
			end
			if (step_x) begin
				if (sel_right)
					rx_q <= edge_x_next;
				else
					lx_q <= edge_x_next;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (s_acc)
			out_vld_q <= 1'b1;
		else if (m_tready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			if (s_tuser == OP_LOAD) begin
				// a load reports only whether the trapezoid was taken
				out_data_q <= {{OPAD{1'b0}}, ld_ok, {(2*SPAN_W){1'b0}}, {CW{1'b0}}};
				out_user_q <= 1'b0;
				out_last_q <= 1'b0;
			end else if (!active_q) begin
				out_data_q <= '0;
				out_user_q <= 1'b0;
				out_last_q <= 1'b0;
			end else begin
				out_data_q <= {{OPAD{1'b0}}, !row_final,
				               row_vld ? xl_k[SPAN_W-1:0] : {SPAN_W{1'b0}},
				               row_vld ? xs_k[SPAN_W-1:0] : {SPAN_W{1'b0}},
				               cur_row_q};
				out_user_q <= row_vld;
				out_last_q <= row_final;
			end
		end
	end

`ifndef SYNTHESIS
	// stepping only runs for a trapezoid that still has rows
	a_step_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> active_q)
		else $error("edge stepping without an active trapezoid");

	// no item is taken while the edges are being stepped
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken during edge stepping");

	// a drawable span never runs backwards
	a_span_order: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_user_q) |->
		(out_data_q[CW +: SPAN_W] <= out_data_q[CW+SPAN_W +: SPAN_W]))
		else $error("span first beyond span last");

	// a row item while idle gives an all-zero result
	a_idle_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && (s_tuser == OP_ROW) && !active_q) |=>
		((out_data_q == '0) && !out_user_q && !out_last_q))
		else $error("row item while idle gave a nonzero result");

	// the left edge moves in x only while it has not reached its goal
	a_left_goal: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LSUB) && at_goal) |=> $stable(lx_q))
		else $error("left edge moved past its goal");
`endif

endmodule

`default_nettype wire
